/* rtl/snau_pkg.sv */
// Package for the spiking neuron array update block: types, codes, constants and arithmetic helpers.
package snau_pkg;

    localparam int NEURON_COUNT_DEF = 1024;
    localparam int DELAY_DEPTH_DEF  = 16;

    // Operation codes of an input item.
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_STEP = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_LOAD = 2'd3;

    // Configuration register indexes.
    localparam int         CFG_IDX_W = 2;
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_RESET_LVL = 2'd1;
    localparam logic [1:0] CFG_TIME_STEP = 2'd2;

    localparam logic signed [31:0] THRESHOLD_RST = 32'sd1966080;
    localparam logic signed [31:0] RESET_LVL_RST = -32'sd4259840;
    localparam logic [16:0]        TIME_STEP_RST = 17'd65536;

    // Model constants in Q15.16.
    localparam logic signed [32:0] K_004 = 33'sd2621;
    localparam logic signed [65:0] K_140 = 66'sd9175040;
    localparam logic signed [32:0] K_02  = 33'sd13107;

    // Datapath commands.
    localparam logic [3:0] DP_NOP     = 4'd0;
    localparam logic [3:0] DP_LOAD    = 4'd1;
    localparam logic [3:0] DP_SPIKE   = 4'd2;
    localparam logic [3:0] DP_MUL_VV  = 4'd3;
    localparam logic [3:0] DP_SQ1     = 4'd4;
    localparam logic [3:0] DP_MUL_K   = 4'd5;
    localparam logic [3:0] DP_SQ2     = 4'd6;
    localparam logic [3:0] DP_DV      = 4'd7;
    localparam logic [3:0] DP_MUL_HDV = 4'd8;
    localparam logic [3:0] DP_VUPD    = 4'd9;
    localparam logic [3:0] DP_MUL_V02 = 4'd10;
    localparam logic [3:0] DP_W       = 4'd11;
    localparam logic [3:0] DP_MUL_AW  = 4'd12;
    localparam logic [3:0] DP_T       = 4'd13;
    localparam logic [3:0] DP_MUL_HT  = 4'd14;
    localparam logic [3:0] DP_UUPD    = 4'd15;

    localparam logic [4:0] STEP_LAST = 5'd20;

    typedef struct packed {
        logic [1:0]         operation;
        logic [9:0]         neuron;
        logic [3:0]         slot_offset;
        logic signed [31:0] current_amount;
        logic signed [31:0] init_membrane;
        logic signed [31:0] init_recovery;
        logic [16:0]        recovery_rate;
        logic signed [21:0] reset_increment;
    } t_item;

    typedef struct packed {
        logic       capture;
        logic       clr_step;
        logic       nrn_we;
        logic       ring_we;
        logic       ptr_adv;
        logic       out_load;
        logic [3:0] code;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       in_range;
        logic       clr_last;
    } t_sts;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Q15.16 product rounding: add half, floor shift by 16, saturate.
    function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
        logic signed [64:0] s;
        s = 65'(p) + 65'sd32768;
        return sat32(66'(s >>> 16));
    endfunction

    // Sequence of one neuron step on the shared multiplier.
    function automatic logic [3:0] step_code(input logic [4:0] s);
        logic [3:0] c;
        case (s)
            5'd0:    c = DP_SPIKE;
            5'd1,
            5'd8:    c = DP_MUL_VV;
            5'd2,
            5'd9:    c = DP_SQ1;
            5'd3,
            5'd10:   c = DP_MUL_K;
            5'd4,
            5'd11:   c = DP_SQ2;
            5'd5,
            5'd12:   c = DP_DV;
            5'd6,
            5'd13:   c = DP_MUL_HDV;
            5'd7,
            5'd14:   c = DP_VUPD;
            5'd15:   c = DP_MUL_V02;
            5'd16:   c = DP_W;
            5'd17:   c = DP_MUL_AW;
            5'd18:   c = DP_T;
            5'd19:   c = DP_MUL_HT;
            5'd20:   c = DP_UUPD;
            default: c = DP_NOP;
        endcase
        return c;
    endfunction

endpackage

/* rtl/snau_if.sv */
// Handshake interfaces for the input items, result items and configuration writes.
interface snau_item_if;
    import snau_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [9:0]         neuron;
    logic [3:0]         slot_offset;
    logic signed [31:0] current_amount;
    logic signed [31:0] init_membrane;
    logic signed [31:0] init_recovery;
    logic [16:0]        recovery_rate;
    logic signed [21:0] reset_increment;
    modport source (output valid, operation, neuron, slot_offset, current_amount,
                    init_membrane, init_recovery, recovery_rate, reset_increment,
                    input ready);
    modport sink (input valid, operation, neuron, slot_offset, current_amount,
                  init_membrane, init_recovery, recovery_rate, reset_increment,
                  output ready);
endinterface

interface snau_res_if;
    logic               valid;
    logic               ready;
    logic [9:0]         neuron_echo;
    logic               spiked;
    logic signed [31:0] membrane_out;
    logic signed [31:0] recovery_out;
    modport source (output valid, neuron_echo, spiked, membrane_out, recovery_out,
                    input ready);
    modport sink (input valid, neuron_echo, spiked, membrane_out, recovery_out,
                  output ready);
endinterface

interface snau_cfg_if;
    import snau_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/snau_ram.sv */
// Generic single-port RAM with registered read data.
module snau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic                                 i_we,
    input  logic [WIDTH-1:0]                     i_wdata,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/snau_ctrl.sv */
// Controller state machine that sequences clearing, memory accesses and the neuron step.
module snau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  snau_pkg::t_sts i_sts,
    output snau_pkg::t_cmd o_cmd
);
    import snau_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_ARITH = 3'd4;
    localparam logic [2:0] S_WB    = 3'd5;
    localparam logic [2:0] S_RES   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [4:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        cmd     = '0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_RD;
                end
            end
            S_RD: begin
                case (i_sts.op)
                    OP_TICK: begin
                        cmd.ptr_adv = 1'b1;
                        n_state     = S_RES;
                    end
                    OP_LOAD: begin
                        cmd.nrn_we = i_sts.in_range;
                        n_state    = S_RES;
                    end
                    default: begin
                        n_state = i_sts.in_range ? S_EXEC : S_RES;
                    end
                endcase
            end
            S_EXEC: begin
                if (i_sts.op == OP_ADD) begin
                    cmd.ring_we = 1'b1;
                    n_state     = S_RES;
                end else begin
                    cmd.code = DP_LOAD;
                    n_step   = '0;
                    n_state  = S_ARITH;
                end
            end
            S_ARITH: begin
                cmd.code = step_code(r_step);
                if (r_step == STEP_LAST) begin
                    n_state = S_WB;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            S_WB: begin
                cmd.nrn_we  = 1'b1;
                cmd.ring_we = 1'b1;
                n_state     = S_RES;
            end
            S_RES: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || cmd.out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !(cmd.nrn_we || cmd.ring_we))
        else $error("memory write while idle");
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == S_RD)
        else $error("accepted item did not start a read");
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_in_ready)
        else $error("item accepted during clearing");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ARITH |-> r_step <= STEP_LAST)
        else $error("step counter out of range");
endmodule

/* rtl/snau_dp.sv */
// Datapath: configuration, item capture, neuron and current memories, shared multiplier.
module snau_dp #(
    parameter int NEURON_COUNT = snau_pkg::NEURON_COUNT_DEF,
    parameter int DELAY_DEPTH  = snau_pkg::DELAY_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [snau_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                      i_cfg_data,
    input  snau_pkg::t_item                  i_item,
    input  snau_pkg::t_cmd                   i_cmd,
    output snau_pkg::t_sts                   o_sts,
    output logic [9:0]                       o_neuron_echo,
    output logic                             o_spiked,
    output logic signed [31:0]               o_membrane_out,
    output logic signed [31:0]               o_recovery_out
);
    import snau_pkg::*;

    localparam int NW         = NEURON_COUNT > 1 ? $clog2(NEURON_COUNT) : 1;
    localparam int SW         = DELAY_DEPTH > 1 ? $clog2(DELAY_DEPTH) : 1;
    localparam int RAW        = NW + SW;
    localparam int RING_DEPTH = NEURON_COUNT * (2 ** SW);
    localparam int NRN_W      = 32 + 32 + 17 + 22;

    // Configuration registers.
    logic signed [31:0] r_thr, r_rst_lvl;
    logic [16:0]        r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THRESHOLD_RST;
            r_rst_lvl <= RESET_LVL_RST;
            r_h       <= TIME_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_thr     <= i_cfg_data;
                CFG_RESET_LVL: r_rst_lvl <= i_cfg_data;
                CFG_TIME_STEP: r_h       <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Captured item, slot pointer and clearing counter.
    t_item          r_item;
    logic [SW-1:0]  r_ptr;
    logic [RAW-1:0] r_clr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_clr <= '0;
        end else begin
            if (i_cmd.ptr_adv) begin
                r_ptr <= (r_ptr == SW'(DELAY_DEPTH - 1)) ? '0 : r_ptr + SW'(1);
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + RAW'(1);
            end
        end
    end

    // Offset reduced modulo DELAY_DEPTH, worked out at elaboration.
    logic [SW-1:0] off_tab [16];
    for (genvar g = 0; g < 16; g++) begin : g_off
        assign off_tab[g] = SW'(g % DELAY_DEPTH);
    end

    logic [SW:0]    slot_sum;
    logic [SW-1:0]  slot_add, slot_sel;
    logic [NW-1:0]  nrn_addr;
    logic           in_range, clr_in_nrn;

    assign slot_sum   = {1'b0, r_ptr} + {1'b0, off_tab[r_item.slot_offset]};
    assign slot_add   = (slot_sum >= (SW+1)'(DELAY_DEPTH))
                        ? SW'(slot_sum - (SW+1)'(DELAY_DEPTH)) : SW'(slot_sum);
    assign slot_sel   = (r_item.operation == OP_STEP) ? r_ptr : slot_add;
    assign nrn_addr   = NW'(r_item.neuron);
    assign in_range   = 32'(r_item.neuron) < 32'(NEURON_COUNT);
    assign clr_in_nrn = 32'(r_clr) < 32'(NEURON_COUNT);

    // Memories.
    logic [NW-1:0]    nrn_ram_addr;
    logic             nrn_ram_we;
    logic [NRN_W-1:0] nrn_wdata, nrn_rdata;
    logic [RAW-1:0]   ring_ram_addr;
    logic             ring_ram_we;
    logic [31:0]      ring_wdata, ring_rdata;

    logic signed [31:0] r_v, r_u, r_cur, r_tmp;
    logic [16:0]        r_a;
    logic signed [21:0] r_d;
    logic               r_spk;
    logic signed [63:0] r_prod;

    assign nrn_ram_addr  = i_cmd.clr_step ? r_clr[NW-1:0] : nrn_addr;
    assign nrn_ram_we    = i_cmd.nrn_we || (i_cmd.clr_step && clr_in_nrn);
    assign ring_ram_addr = i_cmd.clr_step ? r_clr : {nrn_addr, slot_sel};
    assign ring_ram_we   = i_cmd.ring_we || i_cmd.clr_step;

    always_comb begin
        if (i_cmd.clr_step) begin
            nrn_wdata = '0;
        end else if (r_item.operation == OP_LOAD) begin
            nrn_wdata = {r_item.init_membrane, r_item.init_recovery,
                         r_item.recovery_rate, r_item.reset_increment};
        end else begin
            nrn_wdata = {r_v, r_u, r_a, r_d};
        end
        if (i_cmd.clr_step || r_item.operation == OP_STEP) begin
            ring_wdata = '0;
        end else begin
            ring_wdata = sat32(66'($signed(ring_rdata)) + 66'(r_item.current_amount));
        end
    end

    snau_ram #(.WIDTH(NRN_W), .DEPTH(NEURON_COUNT)) u_nrn_ram (
        .i_clk   (i_clk),
        .i_addr  (nrn_ram_addr),
        .i_we    (nrn_ram_we),
        .i_wdata (nrn_wdata),
        .o_rdata (nrn_rdata)
    );

    snau_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_ring_ram (
        .i_clk   (i_clk),
        .i_addr  (ring_ram_addr),
        .i_we    (ring_ram_we),
        .i_wdata (ring_wdata),
        .o_rdata (ring_rdata)
    );

    // Shared multiplier.
    logic signed [32:0] mul_x, mul_y;
    logic signed [65:0] mul_p;
    logic signed [64:0] vround;

    always_comb begin
        case (i_cmd.code)
            DP_MUL_VV:  begin mul_x = 33'(r_v);            mul_y = 33'(r_v);   end
            DP_MUL_K:   begin mul_x = 33'(r_tmp);          mul_y = K_004;      end
            DP_MUL_HDV: begin mul_x = $signed({16'd0, r_h}); mul_y = 33'(r_tmp); end
            DP_MUL_V02: begin mul_x = 33'(r_v);            mul_y = K_02;       end
            DP_MUL_AW:  begin mul_x = $signed({16'd0, r_a}); mul_y = 33'(r_tmp); end
            DP_MUL_HT:  begin mul_x = $signed({16'd0, r_h}); mul_y = 33'(r_tmp); end
            default:    begin mul_x = '0;                  mul_y = '0;         end
        endcase
    end

    assign mul_p  = mul_x * mul_y;
    assign vround = (65'(r_prod) + 65'sd65536) >>> 17;

    always_ff @(posedge i_clk) begin
        case (i_cmd.code)
            DP_LOAD: begin
                r_v   <= $signed(nrn_rdata[102:71]);
                r_u   <= $signed(nrn_rdata[70:39]);
                r_a   <= nrn_rdata[38:22];
                r_d   <= $signed(nrn_rdata[21:0]);
                r_cur <= $signed(ring_rdata);
            end
            DP_SPIKE: begin
                r_spk <= (r_v > r_thr);
                if (r_v > r_thr) begin
                    r_v <= r_rst_lvl;
                    r_u <= sat32(66'(r_u) + 66'(r_d));
                end
            end
            DP_SQ1, DP_SQ2, DP_T: r_tmp <= mulq(r_prod);
            DP_DV: r_tmp <= sat32(66'(r_tmp) + (66'(r_v) <<< 2) + 66'(r_v) + K_140
                                  - 66'(r_u) + 66'(r_cur));
            DP_VUPD: r_v <= sat32(66'(r_v) + 66'(vround));
            DP_W:    r_tmp <= sat32(66'(mulq(r_prod)) - 66'(r_u));
            DP_UUPD: r_u <= sat32(66'(r_u) + 66'(mulq(r_prod)));
            DP_MUL_VV, DP_MUL_K, DP_MUL_HDV, DP_MUL_V02, DP_MUL_AW, DP_MUL_HT:
                r_prod <= $signed(mul_p[63:0]);
            default: ;
        endcase
    end

    // Result register.
    logic               r_res_spk;
    logic [9:0]         r_res_echo;
    logic signed [31:0] r_res_v, r_res_u;
    logic               stepped;

    assign stepped = (r_item.operation == OP_STEP) && in_range;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_res_echo <= (r_item.operation == OP_TICK) ? '0 : r_item.neuron;
            r_res_spk  <= stepped && r_spk;
            r_res_v    <= stepped ? r_v : '0;
            r_res_u    <= stepped ? r_u : '0;
        end
    end

    assign o_neuron_echo  = r_res_echo;
    assign o_spiked       = r_res_spk;
    assign o_membrane_out = r_res_v;
    assign o_recovery_out = r_res_u;

    assign o_sts.op       = r_item.operation;
    assign o_sts.in_range = in_range;
    assign o_sts.clr_last = (r_clr == RAW'(RING_DEPTH - 1));
endmodule

/* rtl/spiking_neuron_array_update.sv */
// Top level of the spiking neuron array update block.
// This block holds an array of Izhikevich neurons (membrane and recovery signed Q15.16 with
// saturation, rate a unsigned Q1.16, reset increment d signed Q5.16) and, for every neuron, a
// ring of delayed input current slots addressed relative to one shared slot pointer. One item
// is worked on at a time. An add-current item passes a read and an execute state before its
// result, and a load, a tick or an item for an out-of-range neuron goes from the read to the
// result. A neuron step is sequenced on the single shared 33 by 33 bit multiplier: the spike
// check, both half Euler steps and the recovery update are taken one operation per cycle.
// The block passes through idle before the next item is taken. A finished result sits in an
// output register, so the block returns to idle as soon as any earlier result has been taken.
// After reset the block runs a clearing pass over NEURON_COUNT times DELAY_DEPTH rounded up to
// a power of two slots (16384 with the defaults), zeroing the neuron and current memories, and
// accepts no item until it is done; configuration writes are taken at all times.
module spiking_neuron_array_update #(
    parameter int NEURON_COUNT = snau_pkg::NEURON_COUNT_DEF,
    parameter int DELAY_DEPTH  = snau_pkg::DELAY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    snau_item_if.sink   i_item,
    snau_res_if.source  o_res,
    snau_cfg_if.sink    i_cfg
);
    import snau_pkg::*;

    t_item item;
    t_cmd  cmd;
    t_sts  sts;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    assign item.operation       = i_item.operation;
    assign item.neuron          = i_item.neuron;
    assign item.slot_offset     = i_item.slot_offset;
    assign item.current_amount  = i_item.current_amount;
    assign item.init_membrane   = i_item.init_membrane;
    assign item.init_recovery   = i_item.init_recovery;
    assign item.recovery_rate   = i_item.recovery_rate;
    assign item.reset_increment = i_item.reset_increment;

    snau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    snau_dp #(
        .NEURON_COUNT (NEURON_COUNT),
        .DELAY_DEPTH  (DELAY_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_item         (item),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_neuron_echo  (o_res.neuron_echo),
        .o_spiked       (o_res.spiked),
        .o_membrane_out (o_res.membrane_out),
        .o_recovery_out (o_res.recovery_out)
    );
endmodule
